@@ rtl/urpm_pkg.sv @@
// ----------------------------------------------------------------------------
// urpm_pkg: shared types and constants of the response pattern matcher
// Holds the window geometry, register indexes, operation codes and the
// request, result and match records passed between the modules.
// ----------------------------------------------------------------------------
package urpm_pkg;

	localparam int WINDOW_BYTES = 8;
	localparam int MAX_EVENTS   = 5;
	localparam int NUM_PATTERNS = MAX_EVENTS + 1;
	localparam int RESP_IDX     = MAX_EVENTS;
	localparam int LEN_W        = 4;
	localparam int SLOT_W       = 3;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int PAT_W        = 8 * WINDOW_BYTES;

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_EVENTS = 3'd0,
		REG_EVENT_A       = 3'd1,
		REG_EVENT_B       = 3'd2,
		REG_EVENT_C       = 3'd3,
		REG_EVENT_D       = 3'd4,
		REG_EVENT_E       = 3'd5,
		REG_RESPONSE      = 3'd6,
		REG_LENGTHS       = 3'd7
	} cfg_reg_t;

	localparam logic OP_RX_BYTE    = 1'b0;
	localparam logic OP_SEND_START = 1'b1;

	typedef struct packed {
		logic  op;
		byte_t rx_byte;
		logic  handler_done;
	} req_t;

	typedef struct packed {
		logic              to_handler;
		logic [SLOT_W-1:0] handler_slot;
		logic              event_hit;
		logic [SLOT_W-1:0] event_slot;
		logic              response_hit;
		logic              done_flag;
	} rsp_t;

	typedef struct packed {
		logic              event_hit;
		logic [SLOT_W-1:0] event_slot;
		logic              response_hit;
	} match_t;

	typedef logic [NUM_PATTERNS-1:0]              hit_vec_t;
	typedef logic [NUM_PATTERNS-1:0][7:0]         pat_bytes_t;
	typedef logic [WINDOW_BYTES-1:0][NUM_PATTERNS-1:0] hit_grid_t;

endpackage

@@ rtl/urpm_cell.sv @@
// ----------------------------------------------------------------------------
// urpm_cell: one byte position of the receive window
// Holds one byte and its valid bit, takes the neighbor's byte on a shift, and
// compares the byte entering it with the same position of every pattern.
// ----------------------------------------------------------------------------
module urpm_cell
	import urpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       clear,
	input  byte_t      byte_in,
	input  logic       valid_in,
	input  pat_bytes_t pat_bytes,
	output byte_t      byte_q,
	output logic       valid_q,
	output hit_vec_t   hit
);

	// The compare looks at the byte this cell holds after the shift.
	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			hit[p] = valid_in && (byte_in == pat_bytes[p]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= valid_in && !clear;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

endmodule

@@ rtl/urpm_match.sv @@
// ----------------------------------------------------------------------------
// urpm_match: suffix decision over the cell row
// Folds the per-cell hits with each pattern's length and picks the
// lowest-indexed event pattern in use, plus the response pattern.
// ----------------------------------------------------------------------------
module urpm_match
	import urpm_pkg::*;
(
	input  hit_grid_t                  cell_hit,
	input  logic [LEN_W*NUM_PATTERNS-1:0] lengths,
	input  logic [SLOT_W-1:0]          active_events,
	output match_t                     result
);

	localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(WINDOW_BYTES);

	hit_vec_t pat_ok;

	always_comb begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			logic [LEN_W-1:0] len;
			len       = lengths[p*LEN_W +: LEN_W];
			pat_ok[p] = (len <= WIN_LEN);
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				if (LEN_W'(i) < len && !cell_hit[i][p]) begin
					pat_ok[p] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		result.event_hit    = 1'b0;
		result.event_slot   = '0;
		for (int p = MAX_EVENTS - 1; p >= 0; p--) begin
			if (SLOT_W'(p) < active_events && pat_ok[p]) begin
				result.event_hit  = 1'b1;
				result.event_slot = SLOT_W'(p);
			end
		end
		result.response_hit = (lengths[RESP_IDX*LEN_W +: LEN_W] != '0) && pat_ok[RESP_IDX];
	end

endmodule

@@ rtl/uart_response_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// uart_response_pattern_matcher: UART event and response pattern matcher
// A row of byte cells holds the last received bytes and matches them against
// five event patterns and one expected-response pattern.
// ----------------------------------------------------------------------------
// Usage:
// Each request on req carries either a received byte (op 0) or a send-start
// marker (op 1) that clears the sticky done flag. Every request produces
// exactly one result on rsp, which says whether the byte went to the engaged
// handler, which event pattern matched, whether the response matched, and
// the done flag after this request.
// The result is registered: a request accepted at one edge has its result
// valid right after that edge. Throughput is one request per cycle while
// results are taken; the figure is set by the single cell row, which shifts
// and compares in the cycle of acceptance. The result sits in an output
// register, so a new request is taken whenever that register is empty or is
// being drained in the same cycle. When the receiver stalls, the result holds
// and req_ready drops only while the held result is not taken.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// must only be made while the block is idle; the block does not enforce it.
// Reset clears the registers, the window's valid bits, the handler state and
// the done flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_response_pattern_matcher
	import urpm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers. Events 0..4 and the response share one array
	// so that every cell can take its byte of every pattern by position.
	logic [SLOT_W-1:0]                    active_events_q;
	logic [NUM_PATTERNS-1:0][PAT_W-1:0]   pattern_q;
	logic [LEN_W*NUM_PATTERNS-1:0]        lengths_q;

	// Handler and flag state.
	logic              handler_engaged_q;
	logic [SLOT_W-1:0] engaged_slot_q;
	logic              response_done_q;

	// Output register.
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic   accept;
	logic   shift_en;
	match_t match;

	// Cell row wiring: cell 0 takes the new byte, cell i the byte of cell i-1.
	byte_t     [WINDOW_BYTES-1:0] cell_byte;
	logic      [WINDOW_BYTES-1:0] cell_valid;
	byte_t     [WINDOW_BYTES-1:0] chain_byte;
	logic      [WINDOW_BYTES-1:0] chain_valid;
	hit_grid_t                    cell_hit;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign shift_en  = accept && (req_data.op == OP_RX_BYTE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_events_q <= '0;
			pattern_q       <= '0;
			lengths_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_EVENTS: active_events_q <= cfg_data[SLOT_W-1:0];
				REG_EVENT_A:       pattern_q[0] <= cfg_data[PAT_W-1:0];
				REG_EVENT_B:       pattern_q[1] <= cfg_data[PAT_W-1:0];
				REG_EVENT_C:       pattern_q[2] <= cfg_data[PAT_W-1:0];
				REG_EVENT_D:       pattern_q[3] <= cfg_data[PAT_W-1:0];
				REG_EVENT_E:       pattern_q[4] <= cfg_data[PAT_W-1:0];
				REG_RESPONSE:      pattern_q[RESP_IDX] <= cfg_data[PAT_W-1:0];
				REG_LENGTHS:       lengths_q <= cfg_data[LEN_W*NUM_PATTERNS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		chain_byte[0]  = req_data.rx_byte;
		chain_valid[0] = 1'b1;
		for (int i = 1; i < WINDOW_BYTES; i++) begin
			chain_byte[i]  = cell_byte[i-1];
			chain_valid[i] = cell_valid[i-1];
		end
	end

	for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
		pat_bytes_t pat_bytes;

		always_comb begin
			for (int p = 0; p < NUM_PATTERNS; p++) begin
				pat_bytes[p] = pattern_q[p][8*i +: 8];
			end
		end

		urpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.clear     (match.response_hit),
			.byte_in   (chain_byte[i]),
			.valid_in  (chain_valid[i]),
			.pat_bytes (pat_bytes),
			.byte_q    (cell_byte[i]),
			.valid_q   (cell_valid[i]),
			.hit       (cell_hit[i])
		);
	end

	urpm_match u_match (
		.cell_hit      (cell_hit),
		.lengths       (lengths_q),
		.active_events (active_events_q),
		.result        (match)
	);

	// A byte first goes to the engaged handler, which may release on it; a
	// new event match then engages its own slot, and a response match sets
	// the sticky flag. A send-start only clears the flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_engaged_q <= 1'b0;
			engaged_slot_q    <= '0;
			response_done_q   <= 1'b0;
			rsp_valid_q       <= 1'b0;
		end else begin
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
				if (req_data.op == OP_SEND_START) begin
					response_done_q <= 1'b0;
				end else begin
					if (handler_engaged_q && req_data.handler_done) begin
						handler_engaged_q <= 1'b0;
					end
					if (match.event_hit) begin
						handler_engaged_q <= 1'b1;
						engaged_slot_q    <= match.event_slot;
					end
					if (match.response_hit) begin
						response_done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_data.op == OP_SEND_START) begin
				rsp_q.to_handler   <= 1'b0;
				rsp_q.handler_slot <= '0;
				rsp_q.event_hit    <= 1'b0;
				rsp_q.event_slot   <= '0;
				rsp_q.response_hit <= 1'b0;
				rsp_q.done_flag    <= 1'b0;
			end else begin
				rsp_q.to_handler   <= handler_engaged_q;
				rsp_q.handler_slot <= handler_engaged_q ? engaged_slot_q : '0;
				rsp_q.event_hit    <= match.event_hit;
				rsp_q.event_slot   <= match.event_slot;
				rsp_q.response_hit <= match.response_hit;
				rsp_q.done_flag    <= match.response_hit || response_done_q;
			end
		end
	end

endmodule

@@ dv/tb_uart_response_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_response_pattern_matcher: self-checking bench of the pattern matcher
// Streams directed and random UART traffic through the request channel. A
// local prediction of the window, handler and done flag is checked against
// every result, across several register settings.
// ----------------------------------------------------------------------------
module tb_uart_response_pattern_matcher;
	import urpm_pkg::*;

	localparam int CLK_HALF_NS       = 2;
	localparam int RESET_CYCLES      = 6;
	localparam int PHASE_REQUESTS    = 125;
	localparam int RANDOM_PHASES     = 8;
	localparam int LONG_STALL_AT     = 60;
	localparam int LONG_STALL_CYCLES = 200;
	localparam int DRAIN_CYCLES      = 8;
	localparam int TIMEOUT_NS        = 2_000_000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req_data  = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	uart_response_pattern_matcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Requests waiting to be offered, and results the matcher still owes us.
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   n_failures = 0;
	int   rsp_count  = 0;

	// Register values of the current phase, indexed by register number. The
	// traffic generator reads them to build sequences that actually match.
	logic [CFG_W-1:0] reg_plan [8];

	// Predicted register contents.
	logic [2:0]       n_events_cfg;
	logic [PAT_W-1:0] event_pat [MAX_EVENTS];
	logic [PAT_W-1:0] response_pat;
	logic [23:0]      len_cfg;

	// Predicted matcher state: the newest byte sits in bits 7:0 of the window.
	logic [PAT_W-1:0] rx_window;
	int               rx_count;
	logic             handler_busy;
	logic [SLOT_W-1:0] busy_slot;
	logic             response_seen;

	initial begin
		n_events_cfg  = '0;
		response_pat  = '0;
		len_cfg       = '0;
		rx_window     = '0;
		rx_count      = 0;
		handler_busy  = 1'b0;
		busy_slot     = '0;
		response_seen = 1'b0;
		for (int i = 0; i < MAX_EVENTS; i++)
			event_pat[i] = '0;
	end

	// Register write as the matcher sees it: the event count keeps three bits
	// and the length word keeps 24, everything else is taken whole.
	function automatic void apply_register(cfg_reg_t idx, logic [CFG_W-1:0] val);
		case (idx)
			REG_ACTIVE_EVENTS: begin
				n_events_cfg = val[2:0];
			end
			REG_EVENT_A, REG_EVENT_B, REG_EVENT_C, REG_EVENT_D, REG_EVENT_E: begin
				event_pat[int'(idx) - int'(REG_EVENT_A)] = val;
			end
			REG_RESPONSE: begin
				response_pat = val;
			end
			REG_LENGTHS: begin
				len_cfg = val[23:0];
			end
			default: begin
			end
		endcase
	endfunction

	// A pattern of len bytes matches when it equals the newest len bytes held
	// since the last clear. Length zero always matches; a length beyond the
	// window can never be reached because the count saturates at the window.
	function automatic logic tail_hit(logic [PAT_W-1:0] pat, int len);
		logic [PAT_W-1:0] mask;
		if (len > rx_count)
			return 1'b0;
		mask = (len >= WINDOW_BYTES) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
		return ((rx_window ^ pat) & mask) == '0;
	endfunction

	// Works out the result of one accepted request and advances the state.
	function automatic rsp_t predict_response(req_t r);
		rsp_t res;
		int   n_act;
		int   rlen;
		res = '0;
		if (r.op == OP_SEND_START) begin
			// A send start only clears the done flag; byte and done bit are ignored.
			response_seen = 1'b0;
		end else begin
			// The engaged handler sees the byte first and may let go of it.
			if (handler_busy) begin
				res.to_handler   = 1'b1;
				res.handler_slot = busy_slot;
				if (r.handler_done)
					handler_busy = 1'b0;
			end
			rx_window = {rx_window[PAT_W-9:0], r.rx_byte};
			if (rx_count < WINDOW_BYTES)
				rx_count++;
			// An event count above the number of slots is treated as all slots.
			n_act = (n_events_cfg > MAX_EVENTS) ? MAX_EVENTS : int'(n_events_cfg);
			for (int i = 0; i < n_act; i++) begin
				if (!res.event_hit && tail_hit(event_pat[i], int'(len_cfg[4*i +: 4]))) begin
					// Lowest slot wins and takes over any handler engaged before.
					res.event_hit  = 1'b1;
					res.event_slot = SLOT_W'(i);
					handler_busy   = 1'b1;
					busy_slot      = SLOT_W'(i);
				end
			end
			// The response is checked after the events, so an event on the
			// same byte still engages, and only then is the window cleared.
			rlen = int'(len_cfg[4*RESP_IDX +: 4]);
			if (rlen != 0 && tail_hit(response_pat, rlen)) begin
				res.response_hit = 1'b1;
				response_seen    = 1'b1;
				rx_window        = '0;
				rx_count         = 0;
			end
		end
		res.done_flag = response_seen;
		return res;
	endfunction

	// Driver: offers queued requests in bursts of random length separated by
	// random gaps. A request stays on the bus unchanged until it is taken,
	// and its result is predicted at the edge that accepts it.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : driver
		logic next_valid;
		req_t next_data;
		next_valid = req_valid;
		next_data  = req_data;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(predict_response(req_data));
				next_valid = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					// A quarter of the bursts run straight into the next one.
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					burst_left = $urandom_range(1, 40);
				end
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0) begin
					next_data  = pending_reqs.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		req_valid <= next_valid;
		req_data  <= next_data;
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_failures++;
		end
	endtask

	// Monitor: checks every taken result against the oldest prediction, and
	// drives rsp_ready from its own stall pattern. Once, after a fixed number
	// of results, it holds ready low for a long stretch so that the output
	// register fills and the request side has to stall.
	int   rcv_mode       = 0;
	int   rcv_left       = 0;
	int   long_stall_cnt = 0;
	logic long_stall_hit = 1'b0;

	always @(posedge clk) begin : monitor
		rsp_t want;
		logic next_ready;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$error("result with no request outstanding: %h", rsp_data);
				n_failures++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("to_handler", 32'(want.to_handler),
					32'(rsp_data.to_handler));
				check_field("handler_slot", 32'(want.handler_slot),
					32'(rsp_data.handler_slot));
				check_field("event_hit", 32'(want.event_hit), 32'(rsp_data.event_hit));
				check_field("event_slot", 32'(want.event_slot), 32'(rsp_data.event_slot));
				check_field("response_hit", 32'(want.response_hit),
					32'(rsp_data.response_hit));
				check_field("done_flag", 32'(want.done_flag), 32'(rsp_data.done_flag));
			end
			rsp_count++;
		end
		if (long_stall_cnt > 0) begin
			long_stall_cnt--;
			next_ready = 1'b0;
		end else if (!long_stall_hit && rsp_count >= LONG_STALL_AT) begin
			long_stall_hit = 1'b1;
			long_stall_cnt = LONG_STALL_CYCLES - 1;
			next_ready     = 1'b0;
		end else begin
			// Stretches of always ready, mostly ready and mostly stalled.
			if (rcv_left == 0) begin
				rcv_mode = $urandom_range(0, 2);
				rcv_left = $urandom_range(16, 80);
			end
			rcv_left--;
			case (rcv_mode)
				0: next_ready = 1'b1;
				1: next_ready = ($urandom_range(0, 3) != 0);
				default: next_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
		rsp_ready <= next_ready;
	end

	task automatic queue_item(logic op, byte_t b, logic done);
		req_t t;
		t.op           = op;
		t.rx_byte      = b;
		t.handler_done = done;
		pending_reqs.push_back(t);
	endtask

	// Registers are only written while nothing is in flight, so the model can
	// take each write at once.
	task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_register(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_plan();
		for (int i = 0; i < 8; i++)
			write_register(cfg_reg_t'(i), reg_plan[i]);
	endtask

	// Returns once every queued request is taken and every result is in. The
	// check runs on the falling edge, when the driver's updates are settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid);
		repeat (2) @(posedge clk);
	endtask

	// Random register set. Pattern bytes come mostly from a four-letter
	// alphabet so that patterns overlap and random traffic hits them; upper
	// bits of the narrow registers are random to show they are dropped.
	function automatic void randomize_plan();
		logic [23:0] lens;
		int          nib;
		reg_plan[REG_ACTIVE_EVENTS] = {$urandom, $urandom};
		reg_plan[REG_ACTIVE_EVENTS][2:0] = 3'($urandom_range(0, 7));
		for (int p = int'(REG_EVENT_A); p <= int'(REG_RESPONSE); p++)
			for (int b = 0; b < WINDOW_BYTES; b++)
				reg_plan[p][8*b +: 8] = ($urandom_range(0, 3) != 0) ?
					8'(8'h41 + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
		for (int k = 0; k < NUM_PATTERNS; k++) begin
			nib = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 15);
			lens[4*k +: 4] = 4'(nib);
		end
		reg_plan[REG_LENGTHS] = {$urandom, $urandom};
		reg_plan[REG_LENGTHS][23:0] = lens;
	endfunction

	// Random traffic: most of it spells out one of the configured patterns
	// byte by byte, the rest is noise bytes and send starts that break the
	// sequences up.
	task automatic queue_traffic(int n_reqs);
		int               queued;
		int               pick;
		int               slot;
		int               len;
		logic [PAT_W-1:0] pat;
		queued = 0;
		while (queued < n_reqs) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				slot = $urandom_range(0, MAX_EVENTS);
				len  = int'(reg_plan[REG_LENGTHS][4*slot +: 4]);
				pat  = (slot == RESP_IDX) ? reg_plan[REG_RESPONSE] :
					reg_plan[int'(REG_EVENT_A) + slot];
				if (len == 0 || len > WINDOW_BYTES) begin
					queue_item(OP_RX_BYTE, byte_t'($urandom_range(0, 255)),
						$urandom_range(0, 3) == 0);
					queued++;
				end else begin
					// Oldest byte of the pattern first.
					for (int j = len - 1; j >= 0; j--)
						queue_item(OP_RX_BYTE, pat[8*j +: 8], $urandom_range(0, 3) == 0);
					queued += len;
				end
			end else if (pick < 92) begin
				queue_item(OP_RX_BYTE, byte_t'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0);
				queued++;
			end else begin
				queue_item(OP_SEND_START, byte_t'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				queued++;
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First directed set: four events in use. Slot 0 is "OK", slot 1 is
		// longer than the window, slot 2 fills the whole window, slot 3 is a
		// line feed, and the response is CR LF.
		reg_plan[REG_ACTIVE_EVENTS] = 64'd4;
		reg_plan[REG_EVENT_A]       = 64'h0000_0000_0000_4F4B;
		reg_plan[REG_EVENT_B]       = '1;
		reg_plan[REG_EVENT_C]       = 64'h0102_0304_0506_0708;
		reg_plan[REG_EVENT_D]       = 64'h0000_0000_0000_000A;
		reg_plan[REG_EVENT_E]       = '0;
		reg_plan[REG_RESPONSE]      = 64'h0000_0000_0000_0D0A;
		reg_plan[REG_LENGTHS]       = 64'h0020_1892;
		load_plan();

		queue_item(OP_RX_BYTE, 8'h00, 1'b0);
		queue_item(OP_RX_BYTE, 8'hFF, 1'b1);
		// "OK" engages handler 0; the next byte goes to it, the one after
		// that goes to it too and releases it.
		queue_item(OP_RX_BYTE, 8'h4F, 1'b0);
		queue_item(OP_RX_BYTE, 8'h4B, 1'b0);
		queue_item(OP_RX_BYTE, 8'h55, 1'b0);
		queue_item(OP_RX_BYTE, 8'h01, 1'b1);
		// Bytes 01..08: the older bytes drop out and the full window matches.
		for (int b = 2; b <= 8; b++)
			queue_item(OP_RX_BYTE, byte_t'(b), 1'b1);
		// Line feed matches an event and the response on the same byte.
		queue_item(OP_RX_BYTE, 8'h0D, 1'b1);
		queue_item(OP_RX_BYTE, 8'h0A, 1'b0);
		// Handler 3 releases on "K" while "OK" engages handler 0 again.
		queue_item(OP_RX_BYTE, 8'h4F, 1'b0);
		queue_item(OP_RX_BYTE, 8'h4B, 1'b1);
		// Send start clears the done flag and ignores its other fields.
		queue_item(OP_SEND_START, 8'hA5, 1'b1);
		queue_item(OP_RX_BYTE, 8'hFF, 1'b0);
		wait_idle();

		// Second directed set: event count beyond the slot count, an empty
		// pattern in the last slot that matches every byte, and a response
		// too long to ever match.
		reg_plan[REG_ACTIVE_EVENTS] = 64'd7;
		reg_plan[REG_LENGTHS]       = 64'h00F0_1892;
		load_plan();
		queue_item(OP_RX_BYTE, 8'h33, 1'b0);
		queue_item(OP_RX_BYTE, 8'h0A, 1'b0);
		queue_item(OP_RX_BYTE, 8'h33, 1'b1);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_plan();
			case (ph)
				0: begin
					// All-ones patterns spanning the full window in every slot.
					reg_plan[REG_ACTIVE_EVENTS] = 64'd5;
					for (int p = int'(REG_EVENT_A); p <= int'(REG_RESPONSE); p++)
						reg_plan[p] = '1;
					reg_plan[REG_LENGTHS] = 64'h0088_8888;
				end
				1: begin
					// No events in use, only the response.
					reg_plan[REG_ACTIVE_EVENTS] = 64'd0;
				end
				2: begin
					// All events in use, response disabled.
					reg_plan[REG_ACTIVE_EVENTS] = 64'd5;
					reg_plan[REG_LENGTHS][4*RESP_IDX +: 4] = 4'd0;
				end
				default: begin
				end
			endcase
			load_plan();
			queue_traffic(PHASE_REQUESTS);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			$error("%0d results never arrived", expected_rsps.size());
			n_failures++;
		end
		if (n_failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog in case the matcher stops answering.
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
